/* rtl/rcs_pkg.sv */
// Shared types and constants of the radar composite selector.
package rcs_pkg;

   localparam int NUM_RADARS  = 4;
   localparam int SAMPLE_BITS = 16;
   localparam int KEY_BITS    = 35;

   localparam logic [15:0] SAMPLE_MASK =
      (SAMPLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SAMPLE_BITS) - 32'd1);

   localparam logic [2:0] WIN_NONE = 3'd4;

   localparam logic [2:0] MODE_QUIET_A = 3'd0;
   localparam logic [2:0] MODE_QUIET_B = 3'd3;

   typedef enum logic [2:0] {
      CSR_SELECT_RULE  = 3'd0,
      CSR_BITMAP_MODE  = 3'd1,
      CSR_NODATA_VALUE = 3'd2,
      CSR_CENTER_X     = 3'd3,
      CSR_CENTER_Y     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic        select_rule;
      logic [15:0] nodata_value;
      logic [63:0] center_x_packed;
      logic [63:0] center_y_packed;
   } front_cfg_type;

   typedef struct packed {
      logic [11:0]         pixel_x;
      logic [11:0]         pixel_y;
      logic [1:0]          radar_id;
      logic                counts;
      logic [15:0]         sample;
      logic [KEY_BITS-1:0] key;
      logic                last_radar;
   } cand_type;

endpackage

/* rtl/rcs_front.sv */
// Front end: accept candidate beats, qualify them and form the selection key.
module rcs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  rcs_pkg::front_cfg_type cfg,
   input  logic                  hold_off,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [11:0]           req_pixel_x,
   input  logic [11:0]           req_pixel_y,
   input  logic [1:0]            req_radar_id,
   input  logic                  req_in_footprint,
   input  logic [15:0]           req_sample,
   input  logic [15:0]           req_beam_height,
   input  logic                  req_last_radar,
   output logic                  push_valid,
   input  logic                  push_ready,
   output rcs_pkg::cand_type     push_data
);
   import rcs_pkg::*;

   logic               advance;
   logic               accept;
   logic signed [15:0] cx;
   logic signed [15:0] cy;
   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic signed [33:0] prod_x;
   logic signed [33:0] prod_y;
   logic               counts;

   logic        s1_valid_ff, s1_valid_in;
   logic [11:0] s1_px_ff;
   logic [11:0] s1_py_ff;
   logic [1:0]  s1_rid_ff;
   logic        s1_counts_ff;
   logic [15:0] s1_sample_ff;
   logic [15:0] s1_height_ff;
   logic        s1_last_ff;
   logic [31:0] s1_sqx_ff;
   logic [31:0] s1_sqy_ff;

   assign advance   = !s1_valid_ff || push_ready;
   assign req_ready = advance && !hold_off;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cx     = cfg.center_x_packed[{req_radar_id, 4'b0000} +: 16];
      cy     = cfg.center_y_packed[{req_radar_id, 4'b0000} +: 16];
      dx     = {cx[15], cx} - $signed({5'b00000, req_pixel_x});
      dy     = {cy[15], cy} - $signed({5'b00000, req_pixel_y});
      prod_x = dx * dx;
      prod_y = dy * dy;
      counts = ({1'b0, req_radar_id} < 3'(NUM_RADARS)) && req_in_footprint &&
               ((req_sample & SAMPLE_MASK) != (cfg.nodata_value & SAMPLE_MASK));
      s1_valid_in = advance ? accept : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff     <= req_pixel_x;
         s1_py_ff     <= req_pixel_y;
         s1_rid_ff    <= req_radar_id;
         s1_counts_ff <= counts;
         s1_sample_ff <= req_sample;
         s1_height_ff <= req_beam_height;
         s1_last_ff   <= req_last_radar;
         s1_sqx_ff    <= prod_x[31:0];
         s1_sqy_ff    <= prod_y[31:0];
      end
   end

   always_comb begin
      push_valid           = s1_valid_ff;
      push_data.pixel_x    = s1_px_ff;
      push_data.pixel_y    = s1_py_ff;
      push_data.radar_id   = s1_rid_ff;
      push_data.counts     = s1_counts_ff;
      push_data.sample     = s1_sample_ff;
      push_data.last_radar = s1_last_ff;
      if (cfg.select_rule) begin
         push_data.key = {19'd0, s1_height_ff};
      end else begin
         push_data.key = {3'd0, s1_sqx_ff} + {3'd0, s1_sqy_ff};
      end
   end

endmodule

/* rtl/rcs_fifo.sv */
// Candidate queue between the front end and the back end.
module rcs_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  rcs_pkg::cand_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output rcs_pkg::cand_type pop_data
);
   import rcs_pkg::*;

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   cand_type        slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PW:0]     count_ff, count_in;
   logic            push;
   logic            pop;

   assign push_ready = count_ff != (PW+1)'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PW+1)'(DEPTH))
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not shrink on pop");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with unequal pointers");
`endif

endmodule

/* rtl/rcs_back.sv */
// Back end: best-radar tracking, line store of winners and result register.
module rcs_back #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        bitmap_mode,
   output logic              clear_busy,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rcs_pkg::cand_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [11:0]       rsp_out_x,
   output logic [11:0]       rsp_out_y,
   output logic [15:0]       rsp_composite_value,
   output logic              rsp_found,
   output logic [1:0]        rsp_chosen_radar,
   output logic              rsp_edge_flag,
   output logic              rsp_edge_write
);
   import rcs_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int XW = 17;

   logic                have_best_ff, have_best_in;
   logic [KEY_BITS-1:0] best_key_ff, best_key_in;
   logic [1:0]          best_radar_ff, best_radar_in;
   logic [15:0]         best_value_ff, best_value_in;

   logic                better;
   logic                nb_have;
   logic [KEY_BITS-1:0] nb_key;
   logic [1:0]          nb_radar;
   logic [15:0]         nb_value;
   logic                pop;
   logic                b1_load;
   logic                b1_free;
   logic                out_load;

   logic [XW-1:0]       rd_ext;
   logic [AW-1:0]       rd_addr;
   logic [XW-1:0]       wr_ext;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;
   logic [2:0]          win;
   logic [2:0]          above;
   logic                edge_flag;

   logic                b1_valid_ff, b1_valid_in;
   logic [11:0]         b1_px_ff;
   logic [11:0]         b1_py_ff;
   logic                b1_found_ff;
   logic [1:0]          b1_radar_ff;
   logic [15:0]         b1_value_ff;
   logic                b1_inrange_ff;
   logic                b1_fwd_ff;
   logic [2:0]          b1_fwd_win_ff;

   logic [2:0]          line_mem [MAX_WIDTH];
   logic [2:0]          rdata_ff;
   logic                clr_busy_ff;
   logic [AW-1:0]       clr_addr_ff;

   logic [2:0]          left_ff, left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [11:0]         rsp_x_ff;
   logic [11:0]         rsp_y_ff;
   logic [15:0]         rsp_value_ff;
   logic                rsp_found_ff;
   logic [1:0]          rsp_radar_ff;
   logic                rsp_edge_ff;
   logic                rsp_write_ff;

   // fold the head beat into the running best
   always_comb begin
      better   = pop_data.counts && (!have_best_ff || pop_data.key < best_key_ff);
      nb_have  = have_best_ff || pop_data.counts;
      nb_key   = better ? pop_data.key : best_key_ff;
      nb_radar = better ? pop_data.radar_id : best_radar_ff;
      nb_value = better ? pop_data.sample : best_value_ff;
   end

   assign out_load  = b1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign b1_free   = !b1_valid_ff || out_load;
   assign pop_ready = !clr_busy_ff && (!pop_data.last_radar || b1_free);
   assign pop       = pop_valid && pop_ready;
   assign b1_load   = pop && pop_data.last_radar;

   always_comb begin
      have_best_in  = have_best_ff;
      best_key_in   = best_key_ff;
      best_radar_in = best_radar_ff;
      best_value_in = best_value_ff;
      if (pop) begin
         have_best_in  = nb_have && !pop_data.last_radar;
         best_key_in   = nb_key;
         best_radar_in = nb_radar;
         best_value_in = nb_value;
      end
   end

   always_comb begin
      rd_ext    = XW'(pop_data.pixel_x);
      rd_addr   = rd_ext[AW-1:0];
      wr_ext    = XW'(b1_px_ff);
      wr_addr   = wr_ext[AW-1:0];
      wr_en     = out_load && b1_inrange_ff;
      win       = b1_found_ff ? {1'b0, b1_radar_ff} : WIN_NONE;
      if (b1_py_ff == '0 || !b1_inrange_ff) begin
         above = WIN_NONE;
      end else if (b1_fwd_ff) begin
         above = b1_fwd_win_ff;
      end else begin
         above = rdata_ff;
      end
      edge_flag = b1_found_ff && (b1_px_ff != '0) && (left_ff != WIN_NONE) &&
                  (above != WIN_NONE) && ((win != left_ff) || (win != above));
      b1_valid_in  = b1_load ? 1'b1 : (out_load ? 1'b0 : b1_valid_ff);
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      left_in      = out_load ? win : left_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= WIN_NONE;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
      end else begin
         have_best_ff <= have_best_in;
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff   <= best_key_in;
      best_radar_ff <= best_radar_in;
      best_value_ff <= best_value_in;
      if (b1_load) begin
         b1_px_ff      <= pop_data.pixel_x;
         b1_py_ff      <= pop_data.pixel_y;
         b1_found_ff   <= nb_have;
         b1_radar_ff   <= nb_have ? nb_radar : 2'd0;
         b1_value_ff   <= nb_have ? nb_value : 16'd0;
         b1_inrange_ff <= rd_ext < XW'(MAX_WIDTH);
         b1_fwd_ff     <= wr_en && (wr_addr == rd_addr);
         b1_fwd_win_ff <= win;
      end
      if (out_load) begin
         rsp_x_ff     <= b1_px_ff;
         rsp_y_ff     <= b1_py_ff;
         rsp_value_ff <= b1_value_ff;
         rsp_found_ff <= b1_found_ff;
         rsp_radar_ff <= b1_radar_ff;
         rsp_edge_ff  <= edge_flag;
         rsp_write_ff <= !((bitmap_mode == MODE_QUIET_A) || (bitmap_mode == MODE_QUIET_B));
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         line_mem[clr_addr_ff] <= WIN_NONE;
      end else if (wr_en) begin
         line_mem[wr_addr] <= win;
      end
      if (b1_load) begin
         rdata_ff <= line_mem[rd_addr];
      end
   end

   assign clear_busy          = clr_busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_x           = rsp_x_ff;
   assign rsp_out_y           = rsp_y_ff;
   assign rsp_composite_value = rsp_value_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_chosen_radar    = rsp_radar_ff;
   assign rsp_edge_flag       = rsp_edge_ff;
   assign rsp_edge_write      = rsp_write_ff;

`ifndef SYNTHESIS
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !b1_valid_ff && !rsp_valid_ff && !have_best_ff)
      else $error("pixel in flight during line store clear");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |->
         rsp_value_ff == '0 && rsp_radar_ff == '0 && !rsp_edge_ff)
      else $error("result without winner carries data");

   a_edge_column: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_edge_ff |-> rsp_found_ff && rsp_x_ff != '0)
      else $error("seam flagged without winner or in first column");

   a_close_slot: assert property (@(posedge clock) disable iff (reset)
      b1_load |-> b1_free)
      else $error("closing beat popped into a busy stage");
`endif

endmodule

/* rtl/radar_composite_select.sv */
// Top level of the radar composite selector: csr bank, front end, queue and back end.
// Throughput: one beat per cycle unless rsp_ready or the line store clear holds it; set
// by the best-key compare in the back end and one line store read and write per pixel.
// Reset: synchronous; a clearing pass then sweeps every line store entry with req_ready
// low, and csr writes are taken throughout.
module radar_composite_select #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   input  logic [1:0]  req_radar_id,
   input  logic        req_in_footprint,
   input  logic [15:0] req_sample,
   input  logic [15:0] req_beam_height,
   input  logic        req_last_radar,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_out_x,
   output logic [11:0] rsp_out_y,
   output logic [15:0] rsp_composite_value,
   output logic        rsp_found,
   output logic [1:0]  rsp_chosen_radar,
   output logic        rsp_edge_flag,
   output logic        rsp_edge_write
);
   import rcs_pkg::*;

   logic        select_rule_ff;
   logic [2:0]  bitmap_mode_ff;
   logic [15:0] nodata_ff;
   logic [63:0] center_x_ff;
   logic [63:0] center_y_ff;

   front_cfg_type front_cfg;
   cand_type      push_data;
   cand_type      pop_data;
   logic          push_valid;
   logic          push_ready;
   logic          pop_valid;
   logic          pop_ready;
   logic          clear_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         select_rule_ff <= 1'b0;
         bitmap_mode_ff <= 3'd0;
         nodata_ff      <= 16'd0;
         center_x_ff    <= 64'd0;
         center_y_ff    <= 64'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SELECT_RULE:  select_rule_ff <= csr_write_data[0];
            CSR_BITMAP_MODE:  bitmap_mode_ff <= csr_write_data[2:0];
            CSR_NODATA_VALUE: nodata_ff      <= csr_write_data[15:0];
            CSR_CENTER_X:     center_x_ff    <= csr_write_data;
            CSR_CENTER_Y:     center_y_ff    <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      front_cfg.select_rule     = select_rule_ff;
      front_cfg.nodata_value    = nodata_ff;
      front_cfg.center_x_packed = center_x_ff;
      front_cfg.center_y_packed = center_y_ff;
   end

   rcs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (front_cfg),
      .hold_off         (clear_busy),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_radar_id     (req_radar_id),
      .req_in_footprint (req_in_footprint),
      .req_sample       (req_sample),
      .req_beam_height  (req_beam_height),
      .req_last_radar   (req_last_radar),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   rcs_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rcs_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .bitmap_mode         (bitmap_mode_ff),
      .clear_busy          (clear_busy),
      .pop_valid           (pop_valid),
      .pop_ready           (pop_ready),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_composite_value (rsp_composite_value),
      .rsp_found           (rsp_found),
      .rsp_chosen_radar    (rsp_chosen_radar),
      .rsp_edge_flag       (rsp_edge_flag),
      .rsp_edge_write      (rsp_edge_write)
   );

endmodule
